>>> rtl/bpms_pkg.sv
// shared types and constants of the battery power-mode supervisor
`timescale 1ns / 1ps

package bpms_pkg;

	typedef enum logic [1:0] {
		FUNC_MEASURE  = 2'd0,
		FUNC_HEALTH   = 2'd1,
		FUNC_SHUTDOWN = 2'd2,
		FUNC_EVALUATE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_SAFE   = 2'd1,
		MODE_OFF    = 2'd2
	} mode_t;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_VOLTAGE   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_VOLTAGE   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OV_MARGIN     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UV_MARGIN     = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_CURRENT   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OC_HOLD       = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_TEMP      = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_TEMP      = 3'd7;

	// one in Q1.16
	localparam logic [16:0] Q16_ONE = 17'h10000;

	typedef struct packed {
		logic volt_high;
		logic volt_low;
		logic amp_high;
		logic amp_sustained;
		logic heat_high;
		logic heat_low;
	} flags_t;

	typedef struct packed {
		flags_t flags;
		logic   oc_started;
		logic   health_seen;
		logic   health_failed;
		logic   health_degraded;
		logic   shutdown;
		mode_t  mode;
	} state_t;

	typedef struct packed {
		logic [15:0] max_voltage;
		logic [15:0] min_voltage;
		logic [15:0] max_current;
		logic [31:0] oc_hold;
		logic [15:0] max_temp;
		logic [15:0] min_temp;
		logic [31:0] high_recover;  // max * (1 - margin), scaled by 2^16
		logic [32:0] low_recover;   // min * (1 + margin), scaled by 2^16
	} cfg_t;

	typedef struct packed {
		mode_t  mode;
		logic   shutdown;
		flags_t flags;
	} result_t;

endpackage

>>> rtl/bpms_if.sv
// valid/ready channel interfaces for items and results
`timescale 1ns / 1ps

interface bpms_item_if #(
	parameter int TIME_BITS = 48
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           func;
	logic [15:0]          voltage_mv;
	logic signed [15:0]   current_ma;
	logic signed [15:0]   temp_decic;
	logic [TIME_BITS-1:0] sample_time_us;
	logic                 sensor_failed;
	logic                 sensor_degraded;
	logic                 shutdown_request;

	modport source (
		output valid, func, voltage_mv, current_ma, temp_decic, sample_time_us,
		output sensor_failed, sensor_degraded, shutdown_request,
		input  ready
	);
	modport sink (
		input  valid, func, voltage_mv, current_ma, temp_decic, sample_time_us,
		input  sensor_failed, sensor_degraded, shutdown_request,
		output ready
	);
endinterface

interface bpms_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] power_mode;
	logic       emergency_shutdown;
	logic       voltage_high;
	logic       voltage_low;
	logic       current_high;
	logic       current_sustained;
	logic       temp_high;
	logic       temp_low;

	modport source (
		output valid, power_mode, emergency_shutdown, voltage_high, voltage_low,
		output current_high, current_sustained, temp_high, temp_low,
		input  ready
	);
	modport sink (
		input  valid, power_mode, emergency_shutdown, voltage_high, voltage_low,
		input  current_high, current_sustained, temp_high, temp_low,
		output ready
	);
endinterface

>>> rtl/bpms_step.sv
// next-state logic for one item: flag updates, overcurrent timing, mode choice
`timescale 1ns / 1ps

module bpms_step #(
	parameter int TIME_BITS = 48
) (
	input  bpms_pkg::cfg_t        cfg,
	input  bpms_pkg::state_t      cur,
	input  logic [TIME_BITS-1:0]  start_time,
	input  bpms_pkg::func_t       func,
	input  logic [15:0]           voltage_mv,
	input  logic [15:0]           current_ma,
	input  logic [15:0]           temp_decic,
	input  logic [TIME_BITS-1:0]  sample_time_us,
	input  logic                  sensor_failed,
	input  logic                  sensor_degraded,
	input  logic                  shutdown_request,
	output bpms_pkg::state_t      nxt,
	output logic [TIME_BITS-1:0]  nxt_start_time
);

	logic [31:0]          v_scaled;
	logic                 any_volt;
	logic                 vh;
	logic                 vl;
	logic                 ah;
	logic [TIME_BITS-1:0] elapsed;
	logic                 any_safe;

	assign v_scaled = {voltage_mv, 16'h0000};
	assign any_volt = cur.flags.volt_high | cur.flags.volt_low;
	assign elapsed  = sample_time_us - start_time;
	assign ah       = $signed(current_ma) > $signed(cfg.max_current);

	always_comb begin
		if (any_volt) begin
			vh = v_scaled > cfg.high_recover;
			vl = {1'b0, v_scaled} < cfg.low_recover;
		end else begin
			vh = voltage_mv > cfg.max_voltage;
			vl = voltage_mv < cfg.min_voltage;
		end
	end

	assign any_safe = (cur.health_seen & cur.health_degraded) | cur.flags.volt_high
		| cur.flags.volt_low | cur.flags.amp_sustained | cur.flags.heat_high
		| cur.flags.heat_low;

	always_comb begin
		nxt            = cur;
		nxt_start_time = start_time;
		case (func)
			bpms_pkg::FUNC_MEASURE: begin
				nxt.flags.volt_high = vh;
				nxt.flags.volt_low  = vl;
				nxt.flags.amp_high  = ah;
				if (ah) begin
					if (cur.oc_started) begin
						nxt.flags.amp_sustained = elapsed > TIME_BITS'(cfg.oc_hold);
					end else begin
						nxt.oc_started = 1'b1;
						nxt_start_time = sample_time_us;
					end
				end else begin
					nxt.flags.amp_sustained = 1'b0;
					nxt.oc_started          = 1'b0;
					nxt_start_time          = '0;
				end
				nxt.flags.heat_high = $signed(temp_decic) > $signed(cfg.max_temp);
				nxt.flags.heat_low  = $signed(temp_decic) < $signed(cfg.min_temp);
			end
			bpms_pkg::FUNC_HEALTH: begin
				nxt.health_seen     = 1'b1;
				nxt.health_failed   = sensor_failed;
				nxt.health_degraded = sensor_degraded;
			end
			bpms_pkg::FUNC_SHUTDOWN: begin
				nxt.shutdown = shutdown_request;
				nxt.mode     = shutdown_request ? bpms_pkg::MODE_OFF : bpms_pkg::MODE_NORMAL;
			end
			bpms_pkg::FUNC_EVALUATE: begin
				if (cur.shutdown || (cur.health_seen && cur.health_failed)) begin
					nxt.mode = bpms_pkg::MODE_OFF;
				end else if (any_safe) begin
					nxt.mode = bpms_pkg::MODE_SAFE;
				end else begin
					nxt.mode = bpms_pkg::MODE_NORMAL;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

>>> rtl/battery_power_mode_supervisor.sv
// top level of the battery power-mode supervisor
// Usage:
//   item channel (valid/ready) carries one beat per request: a measurement,
//   a sensor health update, a shutdown command or an evaluate request,
//   selected by func. result channel returns exactly one beat per item with
//   the power mode, the stored shutdown state and all supervision flags as
//   they stand after that item.
//   Thresholds and margins are loaded through the cfg_we/cfg_index/cfg_wdata
//   write port by the user while no item is in flight (block does not check);
//   the voltage hysteresis recovery thresholds are multiplied out on write.
// Path: an item beat passes the input register, then the result register,
//   with the state update combinational between the two. Throughput: one
//   item per cycle while results are taken (see Stall).
// Reset: all flags, health and shutdown state and the thresholds clear, mode
//   goes to normal, both channels come up empty.
// Stall: a held result keeps its beat; one more item is taken into the input
//   register if it is empty, after which ready drops until the result is taken.
`timescale 1ns / 1ps

module battery_power_mode_supervisor #(
	parameter int TIME_BITS = 48
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	bpms_item_if.sink                              item,
	bpms_result_if.source                          result,
	input  logic                                   cfg_we,
	input  logic [bpms_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [bpms_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

	// configuration
	bpms_pkg::cfg_t cfg_q;
	logic [15:0]    ov_margin_q;
	logic [15:0]    uv_margin_q;
	logic [15:0]    hi_a;
	logic [16:0]    hi_b;
	logic [15:0]    lo_a;
	logic [16:0]    lo_b;
	logic           hi_load;
	logic           lo_load;

	// item register
	logic                 valid_s1;
	bpms_pkg::func_t      func_s1;
	logic [15:0]          voltage_s1;
	logic [15:0]          current_s1;
	logic [15:0]          temp_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic                 failed_s1;
	logic                 degraded_s1;
	logic                 shutdown_s1;

	// supervisor state and result register
	bpms_pkg::state_t     state_q;
	bpms_pkg::state_t     state_nxt;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] start_nxt;
	logic                 rsp_valid_q;
	bpms_pkg::result_t    rsp_q;
	logic                 advance;

	// recovery thresholds follow whichever operand is being written
	assign hi_load = cfg_we && (cfg_index == bpms_pkg::REG_MAX_VOLTAGE
		|| cfg_index == bpms_pkg::REG_OV_MARGIN);
	assign lo_load = cfg_we && (cfg_index == bpms_pkg::REG_MIN_VOLTAGE
		|| cfg_index == bpms_pkg::REG_UV_MARGIN);
	assign hi_a = (cfg_index == bpms_pkg::REG_MAX_VOLTAGE) ? cfg_wdata[15:0] : cfg_q.max_voltage;
	assign hi_b = bpms_pkg::Q16_ONE - {1'b0, (cfg_index == bpms_pkg::REG_OV_MARGIN)
		? cfg_wdata[15:0] : ov_margin_q};
	assign lo_a = (cfg_index == bpms_pkg::REG_MIN_VOLTAGE) ? cfg_wdata[15:0] : cfg_q.min_voltage;
	assign lo_b = bpms_pkg::Q16_ONE + {1'b0, (cfg_index == bpms_pkg::REG_UV_MARGIN)
		? cfg_wdata[15:0] : uv_margin_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= '0;
			ov_margin_q <= '0;
			uv_margin_q <= '0;
		end else begin
			if (hi_load) begin
				cfg_q.high_recover <= 32'(hi_a) * 32'(hi_b);
			end
			if (lo_load) begin
				cfg_q.low_recover <= 33'(lo_a) * 33'(lo_b);
			end
			if (cfg_we) begin
				case (cfg_index)
					bpms_pkg::REG_MAX_VOLTAGE: cfg_q.max_voltage <= cfg_wdata[15:0];
					bpms_pkg::REG_MIN_VOLTAGE: cfg_q.min_voltage <= cfg_wdata[15:0];
					bpms_pkg::REG_OV_MARGIN:   ov_margin_q       <= cfg_wdata[15:0];
					bpms_pkg::REG_UV_MARGIN:   uv_margin_q       <= cfg_wdata[15:0];
					bpms_pkg::REG_MAX_CURRENT: cfg_q.max_current <= cfg_wdata[15:0];
					bpms_pkg::REG_OC_HOLD:     cfg_q.oc_hold     <= cfg_wdata[31:0];
					bpms_pkg::REG_MAX_TEMP:    cfg_q.max_temp    <= cfg_wdata[15:0];
					bpms_pkg::REG_MIN_TEMP:    cfg_q.min_temp    <= cfg_wdata[15:0];
					default: begin
					end
				endcase
			end
		end
	end

	assign advance    = !rsp_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			func_s1     <= bpms_pkg::func_t'(item.func);
			voltage_s1  <= item.voltage_mv;
			current_s1  <= item.current_ma;
			temp_s1     <= item.temp_decic;
			time_s1     <= item.sample_time_us;
			failed_s1   <= item.sensor_failed;
			degraded_s1 <= item.sensor_degraded;
			shutdown_s1 <= item.shutdown_request;
		end
	end

	bpms_step #(
		.TIME_BITS (TIME_BITS)
	) u_step (
		.cfg              (cfg_q),
		.cur              (state_q),
		.start_time       (start_q),
		.func             (func_s1),
		.voltage_mv       (voltage_s1),
		.current_ma       (current_s1),
		.temp_decic       (temp_s1),
		.sample_time_us   (time_s1),
		.sensor_failed    (failed_s1),
		.sensor_degraded  (degraded_s1),
		.shutdown_request (shutdown_s1),
		.nxt              (state_nxt),
		.nxt_start_time   (start_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '{flags: '0, oc_started: 1'b0, health_seen: 1'b0,
				health_failed: 1'b0, health_degraded: 1'b0, shutdown: 1'b0,
				mode: bpms_pkg::MODE_NORMAL};
			start_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
				start_q <= start_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q.mode     <= state_nxt.mode;
			rsp_q.shutdown <= state_nxt.shutdown;
			rsp_q.flags    <= state_nxt.flags;
		end
	end

	assign result.valid              = rsp_valid_q;
	assign result.power_mode         = rsp_q.mode;
	assign result.emergency_shutdown = rsp_q.shutdown;
	assign result.voltage_high       = rsp_q.flags.volt_high;
	assign result.voltage_low        = rsp_q.flags.volt_low;
	assign result.current_high       = rsp_q.flags.amp_high;
	assign result.current_sustained  = rsp_q.flags.amp_sustained;
	assign result.temp_high          = rsp_q.flags.heat_high;
	assign result.temp_low           = rsp_q.flags.heat_low;

endmodule

>>> rtl/bpms_checker.sv
// port-level checks of the supervisor result channel, bound to the top level
`timescale 1ns / 1ps

module bpms_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] power_mode,
	input logic       emergency_shutdown,
	input logic       current_high,
	input logic       current_sustained
);

	// mode is always one of the three legal codes
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (power_mode == bpms_pkg::MODE_NORMAL
			|| power_mode == bpms_pkg::MODE_SAFE || power_mode == bpms_pkg::MODE_OFF))
		else $error("power mode code out of range");

	// stored shutdown can only be entered by a command that also forces off
	a_shutdown_off: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && emergency_shutdown) |-> power_mode == bpms_pkg::MODE_OFF)
		else $error("shutdown stored but mode is not off");

	// sustained overcurrent is cleared by any sample below the limit
	a_sustained_high: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && current_sustained) |-> current_high)
		else $error("sustained overcurrent without overcurrent");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(power_mode)))
		else $error("stalled result beat dropped or changed");

endmodule

bind battery_power_mode_supervisor bpms_checker u_bpms_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (result.valid),
	.rsp_ready          (result.ready),
	.power_mode         (result.power_mode),
	.emergency_shutdown (result.emergency_shutdown),
	.current_high       (result.current_high),
	.current_sustained  (result.current_sustained)
);
